// ===== sv/pafc_pkg.sv =====
// ----------------------------------------------------------------------------
// pafc_pkg: shared types and constants for the particle attractor force core
// Item formats, register indexes, reset values and the side data that rides
// along the square-root and divider pipelines.
// ----------------------------------------------------------------------------
package pafc_pkg;

   // Arithmetic widths.
   localparam int ABS_W   = 33;  // |attractor - position|
   localparam int DIST_W  = 34;  // integer square root of the squared length
   localparam int RAD_W   = 2 * DIST_W;
   localparam int MAG1_W  = 46;  // |strength| * mass in Q16.16
   localparam int PCT_W   = 17;  // falloff factor, up to 1.0
   localparam int PCTQ_W  = 16;  // falloff quotient bits
   localparam int MAG_W   = 46;  // magnitude after falloff
   localparam int PROD_W  = 79;  // |d| * magnitude
   localparam int FQ_W    = 32;  // force quotient bits

   // Register indexes.
   localparam logic [2:0] CSR_ATTRACTOR_X   = 3'd0;
   localparam logic [2:0] CSR_ATTRACTOR_Y   = 3'd1;
   localparam logic [2:0] CSR_ATTRACTOR_Z   = 3'd2;
   localparam logic [2:0] CSR_PULL_STRENGTH = 3'd3;
   localparam logic [2:0] CSR_OUTER_RADIUS  = 3'd4;
   localparam logic [2:0] CSR_INNER_RADIUS  = 3'd5;
   localparam logic [2:0] CSR_CONSUME_EN    = 3'd6;

   // Register reset values (50.0 and 10.0 in Q16.16).
   localparam logic [31:0] OUTER_RESET = 32'd3276800;
   localparam logic [31:0] INNER_RESET = 32'd655360;

   // One input item.
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [30:0]        particle_mass;
   } req_type;

   // One result item.
   typedef struct packed {
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
      logic               force_valid;
      logic               consumed;
   } rsp_type;

   typedef logic [2:0][ABS_W-1:0] absd_type;

   // Side data through the square root.
   typedef struct packed {
      absd_type    absd;
      logic [2:0]  negd;
      logic [30:0] mass;
      logic        on_attr;
   } sq_side_type;

   // Side data through the falloff divider.
   typedef struct packed {
      absd_type          absd;
      logic [2:0]        negd;
      logic [DIST_W-1:0] dist_val;
      logic [MAG1_W-1:0] mag1;
      logic              force_en;
      logic              consumed;
   } pct_side_type;

   // Side data through the force divider.
   typedef struct packed {
      logic [2:0] negd;
      logic [2:0] sat;
      logic       force_en;
      logic       consumed;
   } frc_side_type;

endpackage

// ===== sv/pafc_sqrt.sv =====
// ----------------------------------------------------------------------------
// pafc_sqrt: pipelined integer square root
// One result bit per stage, digit by digit with a running remainder; the
// whole pipe advances when en is high.
// ----------------------------------------------------------------------------
module pafc_sqrt #(
   parameter type side_type = logic
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [pafc_pkg::RAD_W-1:0]   in_rad,
   input  side_type                     in_side,
   output logic                         out_valid,
   output logic [pafc_pkg::DIST_W-1:0]  out_root,
   output side_type                     out_side
);

   localparam int STEPS = pafc_pkg::DIST_W;
   localparam int RW    = pafc_pkg::RAD_W;
   localparam int REM_W = STEPS + 2;
   localparam int T_W   = REM_W + 2;

   logic             valid_ff [STEPS];
   logic [REM_W-1:0] rem_ff   [STEPS];
   logic [STEPS-1:0] root_ff  [STEPS];
   logic [RW-1:0]    rad_ff   [STEPS];
   side_type         side_ff  [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      logic             p_valid;
      logic [REM_W-1:0] p_rem;
      logic [STEPS-1:0] p_root;
      logic [RW-1:0]    p_rad;
      side_type         p_side;
      logic [T_W-1:0]   t;
      logic [T_W-1:0]   trial;
      logic             ge;

      if (k == 0) begin : g_first
         assign p_valid = in_valid;
         assign p_rem   = '0;
         assign p_root  = '0;
         assign p_rad   = in_rad;
         assign p_side  = in_side;
      end else begin : g_next
         assign p_valid = valid_ff[k-1];
         assign p_rem   = rem_ff[k-1];
         assign p_root  = root_ff[k-1];
         assign p_rad   = rad_ff[k-1];
         assign p_side  = side_ff[k-1];
      end

      // Bring down two radicand bits and try root*4+1.
      assign t     = {p_rem, p_rad[RW-1 -: 2]};
      assign trial = T_W'({p_root, 2'b01});
      assign ge    = (t >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= p_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? REM_W'(t - trial) : REM_W'(t);
            root_ff[k] <= {p_root[STEPS-2:0], ge};
            rad_ff[k]  <= {p_rad[RW-3:0], 2'b00};
            side_ff[k] <= p_side;
         end
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

// ===== sv/pafc_div.sv =====
// ----------------------------------------------------------------------------
// pafc_div: pipelined restoring divider with parallel lanes
// Each lane divides {rem, low} by a shared divisor, one quotient bit per
// stage. The starting remainder must be below the divisor.
// ----------------------------------------------------------------------------
module pafc_div #(
   parameter int  LANES = 1,
   parameter int  DW    = 32,
   parameter int  LW    = 16,
   parameter type side_type = logic
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [LANES-1:0][DW-1:0]    in_rem,
   input  logic [LANES-1:0][LW-1:0]    in_low,
   input  logic [DW-1:0]               in_div,
   input  side_type                    in_side,
   output logic                        out_valid,
   output logic [LANES-1:0][LW-1:0]    out_quo,
   output side_type                    out_side
);

   logic                     valid_ff [LW];
   logic [LANES-1:0][DW-1:0] rem_ff   [LW];
   logic [LANES-1:0][LW-1:0] low_ff   [LW];
   logic [DW-1:0]            div_ff   [LW];
   side_type                 side_ff  [LW];

   for (genvar k = 0; k < LW; k++) begin : g_step
      logic                     p_valid;
      logic [LANES-1:0][DW-1:0] p_rem;
      logic [LANES-1:0][LW-1:0] p_low;
      logic [DW-1:0]            p_div;
      side_type                 p_side;
      logic [LANES-1:0][DW-1:0] n_rem;
      logic [LANES-1:0][LW-1:0] n_low;

      if (k == 0) begin : g_first
         assign p_valid = in_valid;
         assign p_rem   = in_rem;
         assign p_low   = in_low;
         assign p_div   = in_div;
         assign p_side  = in_side;
      end else begin : g_next
         assign p_valid = valid_ff[k-1];
         assign p_rem   = rem_ff[k-1];
         assign p_low   = low_ff[k-1];
         assign p_div   = div_ff[k-1];
         assign p_side  = side_ff[k-1];
      end

      // Shift in the next dividend bit; the quotient bit fills the low end.
      always_comb begin
         logic [DW:0] t;
         logic        ge;
         for (int l = 0; l < LANES; l++) begin
            t        = {p_rem[l], p_low[l][LW-1]};
            ge       = (t >= {1'b0, p_div});
            n_rem[l] = ge ? DW'(t - {1'b0, p_div}) : t[DW-1:0];
            n_low[l] = {p_low[l][LW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= p_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= n_rem;
            low_ff[k]  <= n_low;
            div_ff[k]  <= p_div;
            side_ff[k] <= p_side;
         end
      end
   end

   assign out_valid = valid_ff[LW-1];
   assign out_quo   = low_ff[LW-1];
   assign out_side  = side_ff[LW-1];

endmodule

// ===== sv/particle_attractor_force_core.sv =====
// ----------------------------------------------------------------------------
// particle_attractor_force_core: point attractor with linear falloff
// The pipeline has input, difference, magnitude, square and sum registers, a
// 34-stage square root, a range stage, a 16-stage falloff divider, magnitude
// and product registers, a 32-stage force divider and an output register.
// Throughput: one item per cycle; the whole pipeline holds while rsp_stall
// keeps the output item waiting. Reset clears all valid bits and sets the
// registers to their defaults.
// ----------------------------------------------------------------------------
module particle_attractor_force_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pafc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pafc_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int ABS_W  = pafc_pkg::ABS_W;
   localparam int DIST_W = pafc_pkg::DIST_W;
   localparam int MAG_W  = pafc_pkg::MAG_W;
   localparam int PROD_W = pafc_pkg::PROD_W;
   localparam int FQ_W   = pafc_pkg::FQ_W;

   // Configuration registers.
   logic [31:0] attr_x_ff, attr_y_ff, attr_z_ff, strength_ff, outer_ff, inner_ff;
   logic        consume_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_x_ff   <= '0;
         attr_y_ff   <= '0;
         attr_z_ff   <= '0;
         strength_ff <= '0;
         outer_ff    <= pafc_pkg::OUTER_RESET;
         inner_ff    <= pafc_pkg::INNER_RESET;
         consume_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            pafc_pkg::CSR_ATTRACTOR_X:   attr_x_ff   <= csr_wdata;
            pafc_pkg::CSR_ATTRACTOR_Y:   attr_y_ff   <= csr_wdata;
            pafc_pkg::CSR_ATTRACTOR_Z:   attr_z_ff   <= csr_wdata;
            pafc_pkg::CSR_PULL_STRENGTH: strength_ff <= csr_wdata;
            pafc_pkg::CSR_OUTER_RADIUS:  outer_ff    <= csr_wdata;
            pafc_pkg::CSR_INNER_RADIUS:  inner_ff    <= csr_wdata;
            pafc_pkg::CSR_CONSUME_EN:    consume_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The pipeline moves unless a finished item waits at the output.
   logic en;
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // Stage 1: input register.
   logic              v1_ff;
   pafc_pkg::req_type in_ff;

   // Stage 2: signed differences.
   logic                   v2_ff;
   logic [2:0][ABS_W-1:0]  d_ff;
   logic [30:0]            mass2_ff;

   // Stage 3: magnitudes and signs.
   logic                   v3_ff;
   pafc_pkg::sq_side_type  s3_ff;

   // Stage 4: squares.
   logic                   v4_ff;
   logic [2:0][2*ABS_W-1:0] sq_ff;
   pafc_pkg::sq_side_type  s4_ff;

   // Stage 5: sum of squares.
   logic                   v5_ff;
   logic [pafc_pkg::RAD_W-1:0] rad_ff;
   pafc_pkg::sq_side_type  s5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_ff    <= req_data;
         d_ff[0]  <= {attr_x_ff[31], attr_x_ff} - {in_ff.pos_x[31], in_ff.pos_x};
         d_ff[1]  <= {attr_y_ff[31], attr_y_ff} - {in_ff.pos_y[31], in_ff.pos_y};
         d_ff[2]  <= {attr_z_ff[31], attr_z_ff} - {in_ff.pos_z[31], in_ff.pos_z};
         mass2_ff <= in_ff.particle_mass;
         for (int i = 0; i < 3; i++) begin
            s3_ff.negd[i] <= d_ff[i][ABS_W-1];
            s3_ff.absd[i] <= d_ff[i][ABS_W-1] ? (~d_ff[i] + 1'b1) : d_ff[i];
            sq_ff[i]      <= {{ABS_W{1'b0}}, s3_ff.absd[i]} * {{ABS_W{1'b0}}, s3_ff.absd[i]};
         end
         s3_ff.mass    <= mass2_ff;
         s3_ff.on_attr <= (d_ff == '0);
         s4_ff         <= s3_ff;
         rad_ff        <= pafc_pkg::RAD_W'(sq_ff[0]) + pafc_pkg::RAD_W'(sq_ff[1])
                        + pafc_pkg::RAD_W'(sq_ff[2]);
         s5_ff         <= s4_ff;
      end
   end

   // Square root of the squared length.
   logic                  sq_valid;
   logic [DIST_W-1:0]     dist_val;
   pafc_pkg::sq_side_type sq_side;

   pafc_sqrt #(.side_type(pafc_pkg::sq_side_type)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v5_ff),
      .in_rad    (rad_ff),
      .in_side   (s5_ff),
      .out_valid (sq_valid),
      .out_root  (dist_val),
      .out_side  (sq_side)
   );

   // Stage 6: range decisions, strength times mass, falloff dividend.
   logic beyond, capture;
   logic [31:0] str_abs;
   assign beyond  = !outer_ff[31] && (dist_val > DIST_W'(outer_ff));
   assign capture = $signed({1'b0, dist_val})
                  < $signed({{(DIST_W-31){inner_ff[31]}}, inner_ff});
   assign str_abs = strength_ff[31] ? (~strength_ff + 1'b1) : strength_ff;

   logic                   v6_ff;
   pafc_pkg::pct_side_type s6_ff;
   logic [30:0]            prem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (en) begin
         v6_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      logic [61:0] sm;
      if (en) begin
         sm             = {30'b0, str_abs} * {31'b0, sq_side.mass};
         s6_ff.absd     <= sq_side.absd;
         s6_ff.negd     <= sq_side.negd;
         s6_ff.dist_val <= dist_val;
         s6_ff.mag1     <= sm[61:16];
         s6_ff.force_en <= !sq_side.on_attr && !beyond && !capture;
         s6_ff.consumed <= !sq_side.on_attr && !beyond && capture && consume_ff;
         prem_ff        <= outer_ff[30:0] - dist_val[30:0];
      end
   end

   // Falloff quotient (outer - dist) / outer.
   logic                   pq_valid;
   logic [pafc_pkg::PCTQ_W-1:0] pq;
   pafc_pkg::pct_side_type pq_side;

   pafc_div #(
      .LANES(1), .DW(31), .LW(pafc_pkg::PCTQ_W), .side_type(pafc_pkg::pct_side_type)
   ) u_pct_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v6_ff),
      .in_rem    (prem_ff),
      .in_low    ('0),
      .in_div    (outer_ff[30:0]),
      .in_side   (s6_ff),
      .out_valid (pq_valid),
      .out_quo   (pq),
      .out_side  (pq_side)
   );

   // Falloff is 1.0 unless the outer radius is positive.
   logic [pafc_pkg::PCT_W-1:0] pct;
   assign pct = (!outer_ff[31] && outer_ff != '0) ? {1'b0, pq} : 17'h10000;

   // Stage 7: magnitude; stage 8: partial products; stage 9: full products.
   logic                       v7_ff, v8_ff, v9_ff;
   logic [MAG_W-1:0]           mag_ff;
   pafc_pkg::absd_type         absd7_ff;
   logic [2:0][ABS_W+31:0]     plo_ff;
   logic [2:0][ABS_W+13:0]     phi_ff;
   logic [2:0][PROD_W-1:0]     prod_ff;
   logic [DIST_W-1:0]          dist7_ff, dist8_ff, dist9_ff;
   pafc_pkg::frc_side_type     f7_ff, f8_ff, f9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (en) begin
         v7_ff <= pq_valid;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic [62:0] mp;
      if (en) begin
         mp             = {17'b0, pq_side.mag1} * {46'b0, pct};
         mag_ff         <= mp[61:16];
         absd7_ff       <= pq_side.absd;
         dist7_ff       <= pq_side.dist_val;
         f7_ff.negd     <= pq_side.negd;
         f7_ff.sat      <= '0;
         f7_ff.force_en <= pq_side.force_en;
         f7_ff.consumed <= pq_side.consumed;
         for (int i = 0; i < 3; i++) begin
            plo_ff[i]  <= {32'b0, absd7_ff[i]} * {33'b0, mag_ff[31:0]};
            phi_ff[i]  <= {14'b0, absd7_ff[i]} * {33'b0, mag_ff[MAG_W-1:32]};
            prod_ff[i] <= PROD_W'(plo_ff[i]) + {phi_ff[i][PROD_W-33:0], 32'b0};
         end
         dist8_ff <= dist7_ff;
         f8_ff    <= f7_ff;
         dist9_ff <= dist8_ff;
         f9_ff    <= f8_ff;
      end
   end

   // Force divider entry: flag quotients of 2^32 or more as saturated.
   pafc_pkg::frc_side_type   fd_in_side;
   logic [2:0][DIST_W-1:0]   fd_rem;
   logic [2:0][FQ_W-1:0]     fd_low;

   always_comb begin
      fd_in_side = f9_ff;
      for (int i = 0; i < 3; i++) begin
         fd_in_side.sat[i] = prod_ff[i][PROD_W-1:32] >= (PROD_W-32)'(dist9_ff);
         fd_rem[i]         = prod_ff[i][DIST_W+31:32];
         fd_low[i]         = prod_ff[i][31:0];
      end
   end

   logic                   fd_valid;
   logic [2:0][FQ_W-1:0]   fq;
   pafc_pkg::frc_side_type fd_side;

   pafc_div #(
      .LANES(3), .DW(DIST_W), .LW(FQ_W), .side_type(pafc_pkg::frc_side_type)
   ) u_force_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v9_ff),
      .in_rem    (fd_rem),
      .in_low    (fd_low),
      .in_div    (dist9_ff),
      .in_side   (fd_in_side),
      .out_valid (fd_valid),
      .out_quo   (fq),
      .out_side  (fd_side)
   );

   // Output: apply sign, saturate, zero when there is no force.
   logic [2:0][31:0] fval;

   always_comb begin
      logic neg;
      for (int i = 0; i < 3; i++) begin
         neg = fd_side.negd[i] ^ strength_ff[31];
         if (!fd_side.force_en) begin
            fval[i] = '0;
         end else if (neg) begin
            fval[i] = (fd_side.sat[i] || fq[i] > 32'h80000000) ? 32'h80000000
                    : (~fq[i] + 1'b1);
         end else begin
            fval[i] = (fd_side.sat[i] || fq[i][31]) ? 32'h7FFFFFFF : fq[i];
         end
      end
   end

   logic              rsp_valid_ff;
   pafc_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= fd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff.force_x     <= fval[0];
         rsp_ff.force_y     <= fval[1];
         rsp_ff.force_z     <= fval[2];
         rsp_ff.force_valid <= fd_side.force_en;
         rsp_ff.consumed    <= fd_side.consumed;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A force and a capture never come together.
   a_force_not_consumed : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.force_valid && rsp_data.consumed))
      else $error("force and consumed both set");

   // Without a force every component is zero.
   a_no_force_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.force_valid) |->
         (rsp_data.force_x == 0 && rsp_data.force_y == 0 && rsp_data.force_z == 0))
      else $error("nonzero force without force_valid");

   // A waiting output item holds the input side.
   a_stall_back : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("input taken while output item waits");

endmodule
